@@ hdl/rbsm_pkg.sv @@
// rbsm_pkg: shared types and constants for the byte stream RSA block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rbsm_pkg;

   // Default modulus width, exponent width and multiplier operand width.
   localparam int unsigned MOD_BITS_DEF = 20;
   localparam int unsigned EXP_BITS     = 20;
   localparam int unsigned B_BITS       = 24;   // widest base: a gathered 24-bit code
   localparam int unsigned CNT_W        = $clog2(B_BITS + 1);
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned IDX_W        = 2;

   // Register indexes on the csr port
   localparam logic [IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_EXPONENT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MODULUS  = 2'd2;

   // Mode codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_SEND
   } top_state_type;

   typedef enum logic [2:0] {
      EXP_IDLE,
      EXP_REDUCE,
      EXP_DECIDE,
      EXP_MUL,
      EXP_SQR,
      EXP_DONE
   } exp_state_type;

   // Command from the exponentiation sequencer to the serial multiplier
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] nbits;
   } mm_cmd_type;

endpackage

`default_nettype wire

@@ hdl/rbsm_modmul.sv @@
// rbsm_modmul: bit-serial interleaved modular multiplier, one multiplier bit a cycle.
// Depends on rbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsm_modmul #(
   parameter int unsigned MOD_BITS = rbsm_pkg::MOD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbsm_pkg::mm_cmd_type          cmd,
   input  wire logic [MOD_BITS-1:0]           op_a,     // must not exceed modulus
   input  wire logic [rbsm_pkg::B_BITS-1:0]   op_b,     // consumed MSB first
   input  wire logic [MOD_BITS-1:0]           modulus,
   output logic                               done,
   output logic [MOD_BITS-1:0]                result
);
   import rbsm_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0]   b_ff, b_in;

   logic [MOD_BITS:0]   m_ext, t0, t1, t2, t3, add;

   // r = 2r mod m, then r = (r + a) mod m when the top bit of b is set; both stay below 2m
   always_comb begin
      m_ext = {1'b0, modulus};
      t0    = {r_ff, 1'b0};
      t1    = (t0 >= m_ext) ? (t0 - m_ext) : t0;
      add   = b_ff[B_BITS-1] ? {1'b0, a_ff} : '0;
      t2    = t1 + add;
      t3    = (t2 >= m_ext) ? (t2 - m_ext) : t2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.nbits;
         r_in    = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         r_in   = t3[MOD_BITS-1:0];
         b_in   = {b_ff[B_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

`default_nettype wire

@@ hdl/rbsm_exp.sv @@
// rbsm_exp: right-to-left square-and-multiply sequencer around one serial multiplier.
// Depends on rbsm_pkg and rbsm_modmul.
`timescale 1ns / 1ps
`default_nettype none

module rbsm_exp #(
   parameter int unsigned MOD_BITS = rbsm_pkg::MOD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [rbsm_pkg::B_BITS-1:0]     base,
   input  wire logic [rbsm_pkg::EXP_BITS-1:0]   exponent,
   input  wire logic [MOD_BITS-1:0]             modulus,
   output logic                                 done,
   output logic [MOD_BITS-1:0]                  result
);
   import rbsm_pkg::*;

   exp_state_type         state_ff, state_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in;
   logic [MOD_BITS-1:0]   sq_ff, sq_in;
   logic [EXP_BITS-1:0]   ex_ff, ex_in;

   mm_cmd_type            mm_cmd;
   logic [MOD_BITS-1:0]   mm_a;
   logic [B_BITS-1:0]     mm_b;
   logic                  mm_done;
   logic [MOD_BITS-1:0]   mm_res;
   logic [B_BITS-1:0]     sq_top;
   logic [B_BITS-1:0]     acc_top;
   logic                  ex_upper_zero;

   // multiplier bits are taken from the top of op_b
   assign sq_top        = B_BITS'(sq_ff) << (B_BITS - MOD_BITS);
   assign acc_top       = B_BITS'(acc_ff) << (B_BITS - MOD_BITS);
   assign ex_upper_zero = (ex_ff[EXP_BITS-1:1] == '0);

   rbsm_modmul #(.MOD_BITS(MOD_BITS)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mm_cmd),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (modulus),
      .done    (mm_done),
      .result  (mm_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EXP_IDLE: begin
            if (start) state_in = (modulus == '0) ? EXP_DONE : EXP_REDUCE;
         end
         EXP_REDUCE: begin
            if (mm_done) state_in = EXP_DECIDE;
         end
         EXP_DECIDE: begin
            if (ex_ff == '0)   state_in = EXP_DONE;
            else if (ex_ff[0]) state_in = EXP_MUL;
            else               state_in = EXP_SQR;
         end
         EXP_MUL: begin
            if (mm_done) state_in = ex_upper_zero ? EXP_DONE : EXP_SQR;
         end
         EXP_SQR: begin
            if (mm_done) state_in = EXP_DECIDE;
         end
         EXP_DONE: state_in = EXP_IDLE;
         default:  state_in = EXP_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mm_cmd.start = 1'b0;
      mm_cmd.nbits = CNT_W'(MOD_BITS);
      mm_a         = sq_ff;
      mm_b         = sq_top;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      ex_in        = ex_ff;
      unique case (state_ff)
         EXP_IDLE: begin
            if (start) begin
               // 1 mod m: zero for m of 0 or 1
               acc_in = (modulus == '0 || modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
               ex_in  = exponent;
               if (modulus != '0) begin
                  // base mod m as 1 * base
                  mm_cmd.start = 1'b1;
                  mm_cmd.nbits = CNT_W'(B_BITS);
                  mm_a         = MOD_BITS'(1);
                  mm_b         = base;
               end
            end
         end
         EXP_REDUCE: begin
            if (mm_done) sq_in = mm_res;
         end
         EXP_DECIDE: begin
            if (ex_ff != '0) begin
               mm_cmd.start = 1'b1;
               if (ex_ff[0]) begin
                  mm_a = acc_ff;
                  mm_b = sq_top;
               end
            end
         end
         EXP_MUL: begin
            if (mm_done) begin
               acc_in = mm_res;
               if (!ex_upper_zero) mm_cmd.start = 1'b1;
            end
         end
         EXP_SQR: begin
            if (mm_done) begin
               sq_in = mm_res;
               ex_in = ex_ff >> 1;
            end
         end
         EXP_DONE: begin
            mm_b = acc_top;
         end
         default: begin
            mm_b = sq_top;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EXP_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      ex_ff  <= ex_in;
   end

   assign done   = (state_ff == EXP_DONE);
   assign result = acc_ff;

endmodule

`default_nettype wire

@@ hdl/rsa_byte_stream_modexp.sv @@
// Decrypt: first two items of a triple are only gathered; the third starts a run as encrypt.
// Throughput: one item at a time; the next is taken the cycle after the last byte leaves.
// Reset: synchronous, active high; mode 0, exponent 1, modulus 1, gather state cleared.
`timescale 1ns / 1ps
`default_nettype none

module rsa_byte_stream_modexp #(
   parameter int unsigned MOD_BITS = rbsm_pkg::MOD_BITS_DEF   // 8 to 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input stream
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,    // [7:0] data_byte
   // result stream
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [7:0]                        rsp_tdata,    // [7:0] out_byte
   output logic                              rsp_tlast,    // last
   // register writes
   input  wire logic                         csr_we,
   input  wire logic [rbsm_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [((MOD_BITS > rbsm_pkg::EXP_BITS) ?
                       MOD_BITS : rbsm_pkg::EXP_BITS)-1:0] csr_wdata
);
   import rbsm_pkg::*;

   // configuration
   logic                  mode_ff, mode_in;
   logic [EXP_BITS-1:0]   exp_ff, exp_in;
   logic [MOD_BITS-1:0]   mod_ff, mod_in;

   // gather state for decrypt triples
   logic [1:0]            gather_count_ff, gather_count_in;
   logic [15:0]           partial_code_ff, partial_code_in;

   // control and output shifter
   top_state_type         state_ff, state_in;
   logic [B_BITS-1:0]     res_ff, res_in;     // bytes leave from the top
   logic [1:0]            rem_ff, rem_in;     // bytes still to send

   logic                  in_acc, out_acc, triple_done;
   logic                  exp_start, exp_done;
   logic [B_BITS-1:0]     exp_base;
   logic [MOD_BITS-1:0]   exp_res;

   assign in_acc      = req_tvalid && req_tready;
   assign out_acc     = rsp_tvalid && rsp_tready;
   assign triple_done = (gather_count_ff == 2'd2);

   rbsm_exp #(.MOD_BITS(MOD_BITS)) u_exp (
      .clock    (clock),
      .reset    (reset),
      .start    (exp_start),
      .base     (exp_base),
      .exponent (exp_ff),
      .modulus  (mod_ff),
      .done     (exp_done),
      .result   (exp_res)
   );

   // register writes; the user must only write while idle, the block does not enforce it
   always_comb begin
      mode_in = mode_ff;
      exp_in  = exp_ff;
      mod_in  = mod_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:     mode_in = csr_wdata[0];
            CSR_EXPONENT: exp_in  = csr_wdata[EXP_BITS-1:0];
            CSR_MODULUS:  mod_in  = csr_wdata[MOD_BITS-1:0];
            default:      mode_in = mode_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            if (in_acc && (mode_ff == MODE_ENCRYPT || triple_done)) state_in = TOP_RUN;
         end
         TOP_RUN: begin
            if (exp_done) state_in = TOP_SEND;
         end
         TOP_SEND: begin
            if (out_acc && rem_ff == 2'd1) state_in = TOP_IDLE;
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      exp_start       = 1'b0;
      exp_base        = {8'd0, partial_code_ff};
      gather_count_in = gather_count_ff;
      partial_code_in = partial_code_ff;
      res_in          = res_ff;
      rem_in          = rem_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            req_tready = 1'b1;
            if (mode_ff == MODE_ENCRYPT) begin
               exp_base = B_BITS'(req_tdata);
               if (in_acc) exp_start = 1'b1;
            end else begin
               exp_base = {partial_code_ff, req_tdata};
               if (in_acc) begin
                  if (triple_done) begin
                     exp_start       = 1'b1;
                     gather_count_in = 2'd0;
                     partial_code_in = '0;
                  end else begin
                     gather_count_in = gather_count_ff + 2'd1;
                     partial_code_in = {partial_code_ff[7:0], req_tdata};
                  end
               end
            end
         end
         TOP_RUN: begin
            if (exp_done) begin
               if (mode_ff == MODE_ENCRYPT) begin
                  res_in = B_BITS'(exp_res);     // three bytes, big-endian
                  rem_in = 2'd3;
               end else begin
                  res_in = {exp_res[7:0], 16'd0};
                  rem_in = 2'd1;
               end
            end
         end
         TOP_SEND: begin
            rsp_tvalid = 1'b1;
            if (out_acc) begin
               res_in = {res_ff[B_BITS-9:0], 8'd0};
               rem_in = rem_ff - 2'd1;
            end
         end
         default: begin
            rsp_tvalid = 1'b0;
         end
      endcase
      // writing mode restarts gathering
      if (csr_we && csr_index == CSR_MODE) begin
         gather_count_in = 2'd0;
         partial_code_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= TOP_IDLE;
         mode_ff         <= MODE_ENCRYPT;
         exp_ff          <= EXP_BITS'(1);
         mod_ff          <= MOD_BITS'(1);
         gather_count_ff <= '0;
         partial_code_ff <= '0;
         rem_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         exp_ff          <= exp_in;
         mod_ff          <= mod_in;
         gather_count_ff <= gather_count_in;
         partial_code_ff <= partial_code_in;
         rem_ff          <= rem_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tdata = res_ff[B_BITS-1:B_BITS-8];
   assign rsp_tlast = (rem_ff == 2'd1);

endmodule

`default_nettype wire

@@ hdl/rbsm_checker.sv @@
// rbsm_checker: port-level assertions on the byte stream RSA block, bound to its top.
// Depends on rsa_byte_stream_modexp.
`timescale 1ns / 1ps
`default_nettype none

module rbsm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic rsp_tlast
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // one item at a time: no input taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while results pending");

   // bytes of one ciphertext leave back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a result burst");

   // after the last byte the block returns to taking input
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block not idle after last byte");

   // nothing offered straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind rsa_byte_stream_modexp rbsm_checker u_rbsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ verif/rsa_byte_stream_modexp_tb.sv @@
// rsa_byte_stream_modexp_tb: self-checking regression for the byte stream RSA block.
// Predicts every output byte from its own model of the registers and the gather state.
// Depends on rbsm_pkg and rsa_byte_stream_modexp.
`timescale 1ns / 1ps

module rsa_byte_stream_modexp_tb;
   import rbsm_pkg::*;

   localparam int unsigned CSR_W = (MOD_BITS_DEF > EXP_BITS) ? MOD_BITS_DEF : EXP_BITS;
   localparam logic [IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index, a write must do nothing
   localparam logic [EXP_BITS-1:0]     EXP_MASK = '1;
   localparam logic [MOD_BITS_DEF-1:0] MOD_MASK = '1;

   localparam int SETTLE_CYCLES = 64;     // generous margin for any gather to settle
   localparam int TAIL_CYCLES   = 1024;   // tail wait for stray output bytes
   localparam int HOLD_CYCLES   = 3000;   // long output hold-off
   localparam int DRAIN_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 80;     // four idle mixes, at least 320 items in all

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   // DUT signals, all inputs known from time zero
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             csr_we     = 1'b0;
   logic [IDX_W-1:0] csr_index  = CSR_MODE;
   logic [CSR_W-1:0] csr_wdata  = '0;

   // Predictor copy of the registers and the decrypt gather state (reset values)
   logic                    key_mode       = MODE_ENCRYPT;
   logic [EXP_BITS-1:0]     key_exponent   = EXP_BITS'(1);
   logic [MOD_BITS_DEF-1:0] key_modulus    = MOD_BITS_DEF'(1);
   logic [1:0]              gathered_count = '0;
   logic [15:0]             gathered_code  = '0;

   out_byte_type pending_bytes[$];   // output bytes still owed by the block, oldest first

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_left       = 0;       // cycles the receiver still holds rsp_tready low
   int byte_errors     = 0;
   int bytes_checked   = 0;
   int items_accepted  = 0;
   int codes_decrypted = 0;
   int csr_writes      = 0;

   rsa_byte_stream_modexp uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Right-to-left square-and-multiply; a zero modulus cannot reduce, so the answer is 0.
   function automatic logic [MOD_BITS_DEF-1:0] pow_mod(input logic [23:0] base,
                                                      input logic [EXP_BITS-1:0] ex,
                                                      input logic [MOD_BITS_DEF-1:0] m);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned mm;
      if (m == 0) return '0;
      mm  = m;
      acc = 1 % mm;
      sq  = base % mm;
      for (int i = 0; i < EXP_BITS; i++) begin
         if (ex[i]) acc = (acc * sq) % mm;
         sq = (sq * sq) % mm;
      end
      return MOD_BITS_DEF'(acc);
   endfunction

   // Appends one owed byte at the tail of the queue.
   function automatic void owe_byte(input logic [7:0] data, input logic last);
      out_byte_type item;
      item.data = data;
      item.last = last;
      pending_bytes.insert(pending_bytes.size(), item);
   endfunction

   // Works out the output bytes owed for one accepted input byte.
   function automatic void rsa_predict_byte(input logic [7:0] b);
      logic [23:0] r;
      if (key_mode == MODE_ENCRYPT) begin
         // three bytes big-endian; bits above the modulus width read as zero
         r = 24'(pow_mod({16'h0, b}, key_exponent, key_modulus));
         owe_byte(r[23:16], 1'b0);
         owe_byte(r[15:8],  1'b0);
         owe_byte(r[7:0],   1'b1);
      end else if (gathered_count < 2'd2) begin
         // first or second byte of a triple: nothing comes out
         gathered_code  = {gathered_code[7:0], b};
         gathered_count = gathered_count + 2'd1;
      end else begin
         r = 24'(pow_mod({gathered_code, b}, key_exponent, key_modulus));
         gathered_count = '0;
         gathered_code  = '0;
         codes_decrypted++;
         owe_byte(r[7:0], 1'b1);
      end
   endfunction

   // Input monitor: values read here are those sampled at the edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         rsa_predict_byte(req_tdata);
         items_accepted++;
      end
   end

   // Output checker: each accepted byte against the oldest owed byte.
   always @(posedge clock) begin
      out_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            byte_errors++;
            if (byte_errors <= 10)
               $display("%0t: unexpected output byte %02h last %b",
                        $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
               byte_errors++;
               if (byte_errors <= 10)
                  $display("%0t: output byte mismatch: expected %02h last %b, got %02h last %b",
                           $time, want.data, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One input item; tvalid stays high on return so back-to-back items need no re-raise.
   task automatic send_byte(input logic [7:0] b);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering, let every owed byte arrive, then give any gather cycle time to settle.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only ever issued with the block idle.
   task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_MODE: begin
            key_mode       = value[0];
            gathered_count = '0;
            gathered_code  = '0;
         end
         CSR_EXPONENT: key_exponent = value & EXP_MASK;
         CSR_MODULUS:  key_modulus  = value & MOD_MASK;
         default: ;
      endcase
   endtask

   task automatic load_keys(input logic m_sel, input logic [EXP_BITS-1:0] ex,
                            input logic [MOD_BITS_DEF-1:0] n);
      wait_quiet();
      program_reg(CSR_MODE, CSR_W'(m_sel));
      program_reg(CSR_EXPONENT, ex);
      program_reg(CSR_MODULUS, n);
   endtask

   // Random key set for one run of items; each register is rewritten or kept.
   task automatic randomize_keys();
      int               primes[12] = '{2, 3, 53, 61, 251, 257, 509, 521, 1009, 1013, 1019, 1021};
      logic [CSR_W-1:0] v;
      int               pick;
      if ($urandom_range(3) != 0)
         program_reg(CSR_MODE, CSR_W'($urandom));   // upper bits must be ignored
      if ($urandom_range(3) != 0) begin
         pick = $urandom_range(9);
         case (pick)
            0:       v = '0;
            1:       v = EXP_MASK;
            2:       v = CSR_W'(65537);
            default: v = CSR_W'($urandom & ((1 << $urandom_range(EXP_BITS)) - 1));
         endcase
         program_reg(CSR_EXPONENT, v);
      end
      if ($urandom_range(3) != 0) begin
         pick = $urandom_range(15);
         case (pick)
            0:                v = '0;
            1:                v = CSR_W'(1);
            2:                v = MOD_MASK;
            3, 4, 5, 6, 7, 8: v = CSR_W'(primes[$urandom_range(11)] * primes[$urandom_range(11)]);
            default:          v = CSR_W'($urandom);
         endcase
         program_reg(CSR_MODULUS, v);
      end
   endtask

   // Reset keys: exponent 1 over modulus 1, so every byte encrypts to zero.
   task automatic test_reset_values();
      send_byte(8'h00);
      send_byte(8'hff);
      wait_quiet();
   endtask

   task automatic test_encrypt_directed();
      load_keys(MODE_ENCRYPT, 20'd17, 20'd3233);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hff);
      // zero exponent gives one
      wait_quiet();
      program_reg(CSR_EXPONENT, '0);
      send_byte(8'h42);
      // widest exponent and modulus: top byte carries bits 19..16
      wait_quiet();
      program_reg(CSR_EXPONENT, EXP_MASK);
      program_reg(CSR_MODULUS, MOD_MASK);
      send_byte(8'hff);
      send_byte(8'h80);
      // zero modulus: nothing to reduce by, result zero
      wait_quiet();
      program_reg(CSR_MODULUS, '0);
      send_byte(8'haa);
      // a write to the unmapped index must leave the keys alone
      wait_quiet();
      program_reg(CSR_SPARE, '1);
      send_byte(8'h7f);
      wait_quiet();
   endtask

   task automatic test_decrypt_directed();
      load_keys(MODE_DECRYPT, 20'd2753, 20'd3233);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      // largest code, far above the modulus, reduced first
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'hff);
      // code already below the modulus
      send_byte(8'h00);
      send_byte(8'h0b);
      send_byte(8'h0f);
      // exponent write mid-triple keeps the gathered byte
      send_byte(8'h12);
      wait_quiet();
      program_reg(CSR_EXPONENT, 20'd1);
      send_byte(8'h34);
      send_byte(8'h56);
      // mode write drops a partial triple
      send_byte(8'h9a);
      wait_quiet();
      program_reg(CSR_MODE, CSR_W'(MODE_DECRYPT));
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      wait_quiet();
   endtask

   // Output held off while the sender keeps offering, then a burst after a full drain.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_keys(MODE_ENCRYPT, 20'd3, 20'd3233);
      hold_left <= HOLD_CYCLES;
      for (int i = 0; i < 12; i++) send_byte(8'($urandom));
      wait_quiet();
      for (int i = 0; i < 5; i++) send_byte(8'($urandom));
      wait_quiet();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int         sent;
      int         run_len;
      logic [7:0] b;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         wait_quiet();
         randomize_keys();
         run_len = $urandom_range(30, 6);
         // decrypt runs are mostly whole triples; a broken one carries into the next run unless mode is rewritten
         if (key_mode == MODE_DECRYPT && $urandom_range(3) != 0)
            run_len -= run_len % 3;
         for (int i = 0; i < run_len; i++) begin
            b = 8'($urandom);
            if (key_mode == MODE_DECRYPT && i % 3 == 0 && $urandom_range(2) == 0)
               b = 8'($urandom_range(15));   // leading byte small: code often below modulus
            send_byte(b);
         end
         sent += run_len;
      end
   endtask

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_encrypt_directed();
      test_decrypt_directed();
      test_backpressure();
      test_random_traffic(0, 0, PHASE_ITEMS);     // no idling
      test_random_traffic(86, 0, PHASE_ITEMS);    // sparse sender
      test_random_traffic(0, 86, PHASE_ITEMS);    // stalling receiver
      test_random_traffic(25, 25, PHASE_ITEMS);   // both, lightly

      // end of stimulus: bounded wait for owed bytes, then a tail for strays
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items, %0d output bytes checked, %0d codes decrypted, %0d csr writes",
               items_accepted, bytes_checked, codes_decrypted, csr_writes);
      $display("both modes, key extremes, zero modulus, long output hold, four idle mixes");
      if (pending_bytes.size() != 0)
         $display("%0d expected output bytes never arrived", pending_bytes.size());
      if (byte_errors == 0 && pending_bytes.size() == 0) begin
         $display("rsa_byte_stream_modexp regression: pass");
      end else begin
         $display("rsa_byte_stream_modexp regression: fail");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run
   initial begin
      #30_000_000;
      $display("timeout with %0d output bytes owed", pending_bytes.size());
      $display("rsa_byte_stream_modexp regression: fail");
      $finish;
   end

endmodule
